### hw/rtl/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int REQ_W   = 3;
    localparam int POS_W   = 4;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

    typedef logic [REQ_W-1:0] t_req;

    localparam t_req REQ_PUSH_FRONT = 3'd0;
    localparam t_req REQ_PUSH_BACK  = 3'd1;
    localparam t_req REQ_POP_FRONT  = 3'd2;
    localparam t_req REQ_POP_BACK   = 3'd3;
    localparam t_req REQ_INSERT_AT  = 3'd4;
    localparam t_req REQ_FIND       = 3'd5;
    localparam t_req REQ_CLEAR      = 3'd6;

    typedef struct packed {
        logic               ok;
        logic [WORD_W-1:0]  popped_value;
        logic [POS_W-1:0]   found_position;
        logic [COUNT_W-1:0] entry_count;
    } t_result;

endpackage

### hw/rtl/cdq_ram.sv
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_WIDTH-1:0]    i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_WIDTH-1:0]    o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/cdq_ctrl.sv
`timescale 1ns / 1ps

module cdq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  cdq_pkg::t_req                 i_req_type,
    input  logic [cdq_pkg::POS_W-1:0]     i_position,
    input  logic [cdq_pkg::WORD_W-1:0]    i_item_value,
    output logic                          o_res_valid,
    output cdq_pkg::t_result              o_res,
    input  logic                          i_res_take,
    output logic                          o_ram_we,
    output logic [$clog2(DEPTH)-1:0]      o_ram_waddr,
    output logic [DATA_WIDTH-1:0]         o_ram_wdata,
    output logic [$clog2(DEPTH)-1:0]      o_ram_raddr,
    input  logic [DATA_WIDTH-1:0]         i_ram_rdata
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = (CW > cdq_pkg::POS_W) ? CW : cdq_pkg::POS_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EXEC     = 3'd1;
    localparam logic [2:0] ST_POP_WAIT = 3'd2;
    localparam logic [2:0] ST_SHIFT    = 3'd3;
    localparam logic [2:0] ST_FIND     = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    function automatic logic [AW-1:0] slot_fwd(input logic [AW-1:0] s);
        return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] s);
        return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
    endfunction

    // base < DEPTH and off <= DEPTH, so one conditional subtract wraps it
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return AW'(sum);
    endfunction

    logic [2:0]                      r_state, n_state;
    logic [AW-1:0]                   r_head, n_head;
    logic [AW-1:0]                   r_tail, n_tail;
    logic [CW-1:0]                   r_count, n_count;
    cdq_pkg::t_req                   r_req, n_req;
    logic [cdq_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [DATA_WIDTH-1:0]           r_val, n_val;
    logic [AW-1:0]                   r_slot, n_slot;
    logic [CW-1:0]                   r_left, n_left;
    logic                            r_pend, n_pend;
    logic [AW-1:0]                   r_pend_slot, n_pend_slot;
    logic [AW-1:0]                   r_ins_slot, n_ins_slot;
    logic [CW-1:0]                   r_idx, n_idx;
    logic                            r_cmp_valid, n_cmp_valid;
    logic [CW-1:0]                   r_cmp_idx, n_cmp_idx;
    logic                            r_ok, n_ok;
    logic [cdq_pkg::WORD_W-1:0]      r_popped, n_popped;
    logic [cdq_pkg::POS_W-1:0]       r_found, n_found;

    logic                            w_full;
    logic                            w_pos_ok;
    logic                            w_match;
    logic [AW-1:0]                   w_tail_expect;

    assign w_full        = (r_count == CW'(DEPTH));
    assign w_pos_ok      = (CMPW'(r_pos) <= CMPW'(r_count));
    // the one comparator, shared by every step of a find
    assign w_match       = (i_ram_rdata == r_val);
    assign w_tail_expect = slot_add(r_head, r_count);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_req       = r_req;
        n_pos       = r_pos;
        n_val       = r_val;
        n_slot      = r_slot;
        n_left      = r_left;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_ins_slot  = r_ins_slot;
        n_idx       = r_idx;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_ok        = r_ok;
        n_popped    = r_popped;
        n_found     = r_found;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_slot;
        o_ram_wdata = r_val;
        o_ram_raddr = r_slot;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_req    = i_req_type;
                    n_pos    = i_position;
                    n_val    = DATA_WIDTH'(i_item_value);
                    n_ok     = 1'b0;
                    n_popped = '0;
                    n_found  = '0;
                    n_state  = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_state = ST_DONE;
                unique case (r_req)
                    cdq_pkg::REQ_PUSH_FRONT: begin
                        if (!w_full) begin
                            n_head      = slot_back(r_head);
                            o_ram_we    = 1'b1;
                            o_ram_waddr = n_head;
                            n_count     = r_count + CW'(1);
                            n_ok        = 1'b1;
                        end
                    end
                    cdq_pkg::REQ_PUSH_BACK: begin
                        if (!w_full) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_tail;
                            n_tail      = slot_fwd(r_tail);
                            n_count     = r_count + CW'(1);
                            n_ok        = 1'b1;
                        end
                    end
                    cdq_pkg::REQ_POP_FRONT: begin
                        if (r_count != '0) begin
                            o_ram_raddr = r_head;
                            n_state     = ST_POP_WAIT;
                        end
                    end
                    cdq_pkg::REQ_POP_BACK: begin
                        if (r_count != '0) begin
                            n_tail      = slot_back(r_tail);
                            o_ram_raddr = n_tail;
                            n_state     = ST_POP_WAIT;
                        end
                    end
                    cdq_pkg::REQ_INSERT_AT: begin
                        if (!w_full && w_pos_ok) begin
                            n_left     = r_count - CW'(r_pos);
                            n_slot     = slot_back(r_tail);
                            n_ins_slot = slot_add(r_head, CW'(r_pos));
                            n_pend     = 1'b0;
                            n_state    = ST_SHIFT;
                        end
                    end
                    cdq_pkg::REQ_FIND: begin
                        n_slot      = r_head;
                        n_left      = r_count;
                        n_idx       = '0;
                        n_cmp_valid = 1'b0;
                        n_state     = ST_FIND;
                    end
                    cdq_pkg::REQ_CLEAR: begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                        n_ok    = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            ST_POP_WAIT: begin
                n_popped = cdq_pkg::WORD_W'(i_ram_rdata);
                n_ok     = 1'b1;
                n_count  = r_count - CW'(1);
                if (r_req == cdq_pkg::REQ_POP_FRONT) begin
                    n_head = slot_fwd(r_head);
                end
                n_state = ST_DONE;
            end

            // read one entry toward the head while the entry read last cycle
            // lands one slot further toward the tail; then write the new item at its slot
            ST_SHIFT: begin
                if (r_pend) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_pend_slot;
                    o_ram_wdata = i_ram_rdata;
                end
                if (r_left != '0) begin
                    o_ram_raddr = r_slot;
                    n_pend      = 1'b1;
                    n_pend_slot = slot_fwd(r_slot);
                    n_slot      = slot_back(r_slot);
                    n_left      = r_left - CW'(1);
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_ins_slot;
                    o_ram_wdata = r_val;
                    n_count     = r_count + CW'(1);
                    n_tail      = slot_fwd(r_tail);
                    n_ok        = 1'b1;
                    n_state     = ST_DONE;
                end
            end

            ST_FIND: begin
                priority if (r_cmp_valid && w_match) begin
                    n_ok    = 1'b1;
                    n_found = cdq_pkg::POS_W'(r_cmp_idx);
                    n_state = ST_DONE;
                end else if (r_left != '0) begin
                    o_ram_raddr = r_slot;
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_idx;
                    n_idx       = r_idx + CW'(1);
                    n_slot      = slot_fwd(r_slot);
                    n_left      = r_left - CW'(1);
                end else begin
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_pos       <= n_pos;
        r_val       <= n_val;
        r_slot      <= n_slot;
        r_left      <= n_left;
        r_pend_slot <= n_pend_slot;
        r_ins_slot  <= n_ins_slot;
        r_idx       <= n_idx;
        r_cmp_valid <= n_cmp_valid;
        r_cmp_idx   <= n_cmp_idx;
        r_ok        <= n_ok;
        r_popped    <= n_popped;
        r_found     <= n_found;
    end

    assign o_req_ready          = (r_state == ST_IDLE);
    assign o_res_valid          = (r_state == ST_DONE);
    assign o_res.ok             = r_ok;
    assign o_res.popped_value   = r_popped;
    assign o_res.found_position = r_found;
    assign o_res.entry_count    = cdq_pkg::COUNT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    a_tail_tracks_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_tail == w_tail_expect))
        else $error("tail slot out of step with head and count");

    a_no_write_when_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !o_ram_we)
        else $error("store written outside a request");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_res_take) |=> (r_state == ST_DONE))
        else $error("result dropped before transfer");

endmodule

### hw/rtl/circular_deque_store_core.sv
`timescale 1ns / 1ps
// a push, a clear, the unused code and every refused request end in the execute step,
// a pop then waits for its store read, an insert that moves m entries toward the tail
// shifts them one by one, and find reads the n held entries from the head until a match
// one request is in flight at a time; the next is taken once the result has entered
// the output register, which frees as soon as it is transferred
// synchronous active-low reset empties the list; store contents are not cleared

module circular_deque_store_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [cdq_pkg::REQ_W-1:0]      i_req_type,
    input  logic [cdq_pkg::POS_W-1:0]      i_position,
    input  logic [cdq_pkg::WORD_W-1:0]     i_item_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_ok,
    output logic [cdq_pkg::WORD_W-1:0]     o_popped_value,
    output logic [cdq_pkg::POS_W-1:0]      o_found_position,
    output logic [cdq_pkg::COUNT_W-1:0]    o_entry_count
);

    localparam int AW = $clog2(DEPTH);

    logic                  w_res_valid;
    cdq_pkg::t_result      w_res;
    logic                  w_res_take;
    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_waddr;
    logic [DATA_WIDTH-1:0] w_ram_wdata;
    logic [AW-1:0]         w_ram_raddr;
    logic [DATA_WIDTH-1:0] w_ram_rdata;

    logic                  r_out_valid;
    cdq_pkg::t_result      r_out;

    cdq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .o_req_ready  (o_ready),
        .i_req_type   (i_req_type),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_take   (w_res_take),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata)
    );

    cdq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // output register takes a new result once the held one is transferred
    assign w_res_take = w_res_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_ok             = r_out.ok;
    assign o_popped_value   = r_out.popped_value;
    assign o_found_position = r_out.found_position;
    assign o_entry_count    = r_out.entry_count;

endmodule

### verif/circular_deque_store_core_test.sv
`timescale 1ns / 1ps

class deque_ledger;
    localparam int SLOTS = 16;

    logic [cdq_pkg::WORD_W-1:0]  words [SLOTS];
    logic [cdq_pkg::POS_W-1:0]   head;
    logic [cdq_pkg::POS_W-1:0]   tail;
    logic [cdq_pkg::COUNT_W-1:0] count;
    cdq_pkg::t_result            outcome_q [$];
    int                          mismatches;
    int                          checked;
    int                          full_hits;
    int                          empty_hits;

    function new();
        head       = '0;
        tail       = '0;
        count      = '0;
        mismatches = 0;
        checked    = 0;
        full_hits  = 0;
        empty_hits = 0;
        foreach (words[i]) words[i] = '0;
    endfunction

    function logic [cdq_pkg::POS_W-1:0] slot_at(int off);
        return head + cdq_pkg::POS_W'(off);
    endfunction

    function logic [cdq_pkg::WORD_W-1:0] word_at(int off);
        return words[slot_at(off)];
    endfunction

    // advance the shadow list by one accepted request and queue its outcome
    function void apply_request(cdq_pkg::t_req req, logic [cdq_pkg::POS_W-1:0] pos,
                                logic [cdq_pkg::WORD_W-1:0] value);
        cdq_pkg::t_result outcome;
        int               i;
        bit               hit;
        outcome = '0;
        hit     = 1'b0;
        case (req)
            cdq_pkg::REQ_PUSH_FRONT: begin
                if (count < SLOTS) begin
                    head        = head - 1'b1;
                    words[head] = value;
                    count       = count + 1'b1;
                    outcome.ok  = 1'b1;
                end
            end
            cdq_pkg::REQ_PUSH_BACK: begin
                if (count < SLOTS) begin
                    words[tail] = value;
                    tail        = tail + 1'b1;
                    count       = count + 1'b1;
                    outcome.ok  = 1'b1;
                end
            end
            cdq_pkg::REQ_POP_FRONT: begin
                if (count > 0) begin
                    outcome.popped_value = words[head];
                    head                 = head + 1'b1;
                    count                = count - 1'b1;
                    outcome.ok           = 1'b1;
                end
            end
            cdq_pkg::REQ_POP_BACK: begin
                if (count > 0) begin
                    tail                 = tail - 1'b1;
                    outcome.popped_value = words[tail];
                    count                = count - 1'b1;
                    outcome.ok           = 1'b1;
                end
            end
            cdq_pkg::REQ_INSERT_AT: begin
                if (count < SLOTS && pos <= count) begin
                    // later entries shift one slot toward the tail
                    for (i = count; i > pos; i--) begin
                        words[slot_at(i)] = words[slot_at(i - 1)];
                    end
                    words[slot_at(pos)] = value;
                    count               = count + 1'b1;
                    tail                = tail + 1'b1;
                    outcome.ok          = 1'b1;
                end
            end
            cdq_pkg::REQ_FIND: begin
                for (i = 0; i < count && !hit; i++) begin
                    if (words[slot_at(i)] == value) begin
                        hit                    = 1'b1;
                        outcome.ok             = 1'b1;
                        outcome.found_position = cdq_pkg::POS_W'(i);
                    end
                end
            end
            cdq_pkg::REQ_CLEAR: begin
                head       = '0;
                tail       = '0;
                count      = '0;
                outcome.ok = 1'b1;
            end
            default: begin
            end
        endcase
        outcome.entry_count = count;
        if (count == SLOTS) full_hits++;
        if (count == 0) empty_hits++;
        outcome_q.push_back(outcome);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void compare_outcome(cdq_pkg::t_result got);
        cdq_pkg::t_result want;
        if (outcome_q.size() == 0) begin
            $display("%0t: result with nothing outstanding, actual ok=%b popped=%h",
                     $time, got.ok, got.popped_value);
            $display("%0t: actual pos=%0d count=%0d",
                     $time, got.found_position, got.entry_count);
            mismatches++;
        end else begin
            want = outcome_q.pop_front();
            checked++;
            field_check("ok", 32'(want.ok), 32'(got.ok));
            field_check("popped_value", want.popped_value, got.popped_value);
            field_check("found_position", 32'(want.found_position), 32'(got.found_position));
            field_check("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        end
    endfunction
endclass

module circular_deque_store_core_test;

    localparam cdq_pkg::t_req REQ_UNUSED   = 3'd7;
    localparam int            RANDOM_ITEMS = 650;
    localparam int            IDLE_LIMIT   = 2000;
    localparam int            HOLD_CYCLES  = 250;
    localparam int            DRAIN_CYCLES = 40;

    typedef enum int {FILL_UP, MIXED, DRAIN_DOWN} t_mix;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [cdq_pkg::REQ_W-1:0]    i_req_type;
    logic [cdq_pkg::POS_W-1:0]    i_position;
    logic [cdq_pkg::WORD_W-1:0]   i_item_value;
    logic                         o_valid;
    logic                         i_ready;
    logic                         o_ok;
    logic [cdq_pkg::WORD_W-1:0]   o_popped_value;
    logic [cdq_pkg::POS_W-1:0]    o_found_position;
    logic [cdq_pkg::COUNT_W-1:0]  o_entry_count;

    deque_ledger ledger = new();
    int          sent;
    int          received;
    int          req_seen [8];

    circular_deque_store_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_req_type       (i_req_type),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_ok             (o_ok),
        .o_popped_value   (o_popped_value),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // returns at the edge of the transfer; valid stays high unless the next call idles
    task automatic send_request(cdq_pkg::t_req req, logic [cdq_pkg::POS_W-1:0] pos,
                                logic [cdq_pkg::WORD_W-1:0] value);
        bit quiet;
        quiet = (sent >= 300 && sent < 420);
        if (!quiet && $urandom_range(0, 99) < 31) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 31);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_position   <= pos;
        i_item_value <= value;
        do @(posedge i_clk); while (!o_ready);
        ledger.apply_request(req, pos, value);
        req_seen[req]++;
        sent++;
    endtask

    task automatic random_request(t_mix mix);
        cdq_pkg::t_req              req;
        logic [cdq_pkg::POS_W-1:0]  pos;
        logic [cdq_pkg::WORD_W-1:0] value;
        int                         roll;
        int                         grow;
        int                         pick_held;
        grow = (mix == FILL_UP) ? 70 : (mix == DRAIN_DOWN) ? 20 : 42;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            req = REQ_UNUSED;
        end else if (roll < 5) begin
            req = (mix == FILL_UP) ? cdq_pkg::REQ_PUSH_BACK : cdq_pkg::REQ_CLEAR;
        end else if (roll < 5 + grow) begin
            case ($urandom_range(0, 2))
                0:       req = cdq_pkg::REQ_PUSH_FRONT;
                1:       req = cdq_pkg::REQ_PUSH_BACK;
                default: req = cdq_pkg::REQ_INSERT_AT;
            endcase
        end else if (roll < 84) begin
            req = $urandom_range(0, 1) ? cdq_pkg::REQ_POP_FRONT : cdq_pkg::REQ_POP_BACK;
        end else begin
            req = cdq_pkg::REQ_FIND;
        end
        // mostly legal insert positions, some past the end
        if ($urandom_range(0, 99) < 75) pos = cdq_pkg::POS_W'($urandom_range(0, ledger.count));
        else pos = cdq_pkg::POS_W'($urandom_range(0, 15));
        // reuse held words so that finds hit and duplicates appear
        pick_held = (req == cdq_pkg::REQ_FIND) ? 65 : 25;
        roll = $urandom_range(0, 99);
        if (roll < pick_held && ledger.count != 0)
            value = ledger.word_at($urandom_range(0, ledger.count - 1));
        else if (roll < pick_held + 8) value = roll[0] ? '1 : '0;
        else value = $urandom();
        send_request(req, pos, value);
    endtask

    initial begin : stimulus
        int   n;
        t_mix mix;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_req_type   <= cdq_pkg::REQ_PUSH_FRONT;
        i_position   <= '0;
        i_item_value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(cdq_pkg::REQ_POP_FRONT, 4'd0, 32'h0000_0000);
        send_request(cdq_pkg::REQ_POP_BACK, 4'd0, 32'h0000_0000);
        send_request(cdq_pkg::REQ_FIND, 4'd0, 32'h0000_0000);
        send_request(cdq_pkg::REQ_INSERT_AT, 4'd1, 32'h1111_1111);
        send_request(cdq_pkg::REQ_INSERT_AT, 4'd15, 32'hffff_ffff);
        send_request(cdq_pkg::REQ_INSERT_AT, 4'd0, 32'hffff_ffff);
        send_request(cdq_pkg::REQ_PUSH_BACK, 4'd0, 32'h0000_0000);
        send_request(cdq_pkg::REQ_PUSH_FRONT, 4'd0, 32'h8000_0001);
        send_request(cdq_pkg::REQ_INSERT_AT, 4'd3, 32'h0000_1234);
        send_request(cdq_pkg::REQ_INSERT_AT, 4'd1, 32'ha5a5_5a5a);
        send_request(cdq_pkg::REQ_FIND, 4'd0, 32'hffff_ffff);
        send_request(cdq_pkg::REQ_FIND, 4'd0, 32'h0000_1234);
        send_request(cdq_pkg::REQ_FIND, 4'd0, 32'h8000_0001);
        send_request(cdq_pkg::REQ_FIND, 4'd0, 32'h0000_0007);
        send_request(cdq_pkg::REQ_FIND, 4'd0, 32'h0000_0000);
        send_request(REQ_UNUSED, 4'd15, 32'hffff_ffff);
        send_request(cdq_pkg::REQ_POP_BACK, 4'd0, 32'h0000_0000);
        send_request(cdq_pkg::REQ_POP_FRONT, 4'd0, 32'h0000_0000);
        send_request(cdq_pkg::REQ_INSERT_AT, 4'd15, 32'h0f0f_0f0f);
        send_request(cdq_pkg::REQ_CLEAR, 4'd0, 32'h0000_0000);
        send_request(cdq_pkg::REQ_FIND, 4'd0, 32'ha5a5_5a5a);
        // head wraps below slot zero right after a clear
        send_request(cdq_pkg::REQ_PUSH_FRONT, 4'd0, 32'h0000_0000);
        send_request(cdq_pkg::REQ_POP_BACK, 4'd0, 32'h0000_0000);
        send_request(cdq_pkg::REQ_PUSH_BACK, 4'd0, 32'hffff_ffff);
        send_request(cdq_pkg::REQ_POP_FRONT, 4'd0, 32'h0000_0000);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / 40) % 4)
                0:       mix = FILL_UP;
                2:       mix = DRAIN_DOWN;
                default: mix = MIXED;
            endcase
            random_request(mix);
        end
        i_valid <= 1'b0;

        while (ledger.outcome_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d push, %0d pop, %0d insert",
                 sent,
                 req_seen[cdq_pkg::REQ_PUSH_FRONT] + req_seen[cdq_pkg::REQ_PUSH_BACK],
                 req_seen[cdq_pkg::REQ_POP_FRONT] + req_seen[cdq_pkg::REQ_POP_BACK],
                 req_seen[cdq_pkg::REQ_INSERT_AT]);
        $display("%0d find, %0d clear, %0d unused code",
                 req_seen[cdq_pkg::REQ_FIND], req_seen[cdq_pkg::REQ_CLEAR],
                 req_seen[REQ_UNUSED]);
        $display("%0d results checked, list full %0d times, empty %0d times, %0d mismatches",
                 ledger.checked, ledger.full_hits, ledger.empty_hits, ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.checked == sent) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : result_sink
        int               hold;
        bit               held_once;
        cdq_pkg::t_result got;
        hold      = 0;
        held_once = 1'b0;
        i_ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                got.ok             = o_ok;
                got.popped_value   = o_popped_value;
                got.found_position = o_found_position;
                got.entry_count    = o_entry_count;
                ledger.compare_outcome(got);
                received++;
            end
            // one long stall so the block backs up and drops o_ready
            if (!held_once && received == 150) begin
                held_once = 1'b1;
                hold      = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (received >= 300 && received < 420) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 31);
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle = 0;
            else idle++;
        end
        $display("no transfer for %0d cycles at %0t", IDLE_LIMIT, $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### circular_deque_store_core.f
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ram.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/circular_deque_store_core.sv
verif/circular_deque_store_core_test.sv
